// File: rtl/dlwb_pkg.sv
// ----------------------------------------------------------------------------
// Dirty-line write-back buffer package
// Shared widths, item codes, controller states and the item, result and
// command types of the write-back buffer.
// ----------------------------------------------------------------------------
package dlwb_pkg;

	localparam int ADDR_W   = 12;
	localparam int DATA_W   = 8;
	localparam int KIND_W   = 3;
	localparam int FLINE_W  = 3;
	localparam int LIDX_W   = 3;

	localparam int STORE_BYTES_DEF = 4096;
	localparam int LINE_SHIFT_DEF  = 9;
	localparam int NUM_LINES_DEF   = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_READ  = 3'd0,
		KIND_WRITE = 3'd1,
		KIND_LOAD  = 3'd2,
		KIND_TICK  = 3'd3,
		KIND_FAIL  = 3'd4
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ADDR_W-1:0]  address;
		logic [DATA_W-1:0]  data_byte;
		logic               block_end;
		logic [FLINE_W-1:0] failed_line;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              line_valid;
		logic [LIDX_W-1:0] line_index;
	} result_t;

	typedef struct packed {
		logic launch;
		logic finish;
	} cmd_t;

endpackage

// File: rtl/dlwb_ctrl.sv
// ----------------------------------------------------------------------------
// Dirty-line write-back buffer controller
// Two-state sequencer: takes an item, then lets the datapath finish it.
// ----------------------------------------------------------------------------
module dlwb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output dlwb_pkg::cmd_t cmd
);

	dlwb_pkg::state_t state_q;
	dlwb_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlwb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.launch = 1'b0;
		cmd.finish = 1'b0;
		busy       = 1'b0;
		case (state_q)
			dlwb_pkg::ST_IDLE: begin
				if (start) begin
					cmd.launch = 1'b1;
					state_d    = dlwb_pkg::ST_EXEC;
				end
			end
			dlwb_pkg::ST_EXEC: begin
				busy       = 1'b1;
				cmd.finish = 1'b1;
				state_d    = dlwb_pkg::ST_IDLE;
			end
			default: begin
				state_d = dlwb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/dlwb_datapath.sv
// ----------------------------------------------------------------------------
// Dirty-line write-back buffer datapath
// Byte store, dirty line bitmap, write run tracking and the result register.
// ----------------------------------------------------------------------------
module dlwb_datapath #(
	parameter int STORE_BYTES = dlwb_pkg::STORE_BYTES_DEF,
	parameter int LINE_SHIFT  = dlwb_pkg::LINE_SHIFT_DEF,
	parameter int NUM_LINES   = dlwb_pkg::NUM_LINES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dlwb_pkg::cmd_t    cmd,
	input  dlwb_pkg::item_t   item,
	output logic              done,
	output dlwb_pkg::result_t result
);

	localparam int AW        = dlwb_pkg::ADDR_W;
	localparam int DW        = dlwb_pkg::DATA_W;
	localparam int OIW       = dlwb_pkg::LIDX_W;
	localparam int ADDR_SPAN = 2 ** AW;
	localparam int MEM_DEPTH = (STORE_BYTES < ADDR_SPAN) ? STORE_BYTES : ADDR_SPAN;
	localparam int MIDX_W    = $clog2(MEM_DEPTH);
	localparam int LINE_W    = (LINE_SHIFT < AW) ? (AW - LINE_SHIFT) : 1;
	localparam int DIDX_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

	logic [DW-1:0]        mem [MEM_DEPTH];
	logic [DW-1:0]        rdata_q;
	dlwb_pkg::item_t      item_q;
	logic                 in_store_q;
	logic                 in_store;
	logic                 store_wr;

	logic [NUM_LINES-1:0] dirty_q;
	logic [NUM_LINES-1:0] dirty_d;
	logic                 run_open_q;
	logic                 run_open_d;
	logic                 run_changed_q;
	logic                 run_changed_d;
	logic [LINE_W-1:0]    run_start_q;
	logic [LINE_W-1:0]    run_start_d;
	logic                 done_q;
	dlwb_pkg::result_t    result_q;
	dlwb_pkg::result_t    result_d;

	logic [AW-1:0]        line_full;
	logic [LINE_W-1:0]    cur_line;
	logic [LINE_W-1:0]    first_line;
	logic [LINE_W-1:0]    lo_line;
	logic [LINE_W-1:0]    hi_line;
	logic                 changed;
	logic [NUM_LINES-1:0] mark;
	logic [NUM_LINES-1:0] lowest;
	logic [DIDX_W-1:0]    lowest_idx;
	logic                 fail_hit;
	logic [NUM_LINES-1:0] fail_mask;

	assign in_store = 32'(item.address) < 32'(STORE_BYTES);
	assign store_wr = in_store && ((item.kind == dlwb_pkg::KIND_WRITE) ||
		(item.kind == dlwb_pkg::KIND_LOAD));

	// Read-first single-port store: the old byte is read as the new one lands.
	always_ff @(posedge clk) begin
		if (cmd.launch) begin
			rdata_q    <= mem[item.address[MIDX_W-1:0]];
			item_q     <= item;
			in_store_q <= in_store;
			if (store_wr) begin
				mem[item.address[MIDX_W-1:0]] <= item.data_byte;
			end
		end
	end

	assign line_full  = item_q.address >> LINE_SHIFT;
	assign cur_line   = line_full[LINE_W-1:0];
	assign first_line = run_open_q ? run_start_q : cur_line;
	assign changed    = (run_open_q && run_changed_q) ||
		(in_store_q && (rdata_q != item_q.data_byte));
	assign lo_line    = (first_line < cur_line) ? first_line : cur_line;
	assign hi_line    = (first_line < cur_line) ? cur_line : first_line;

	always_comb begin
		mark       = '0;
		lowest_idx = '0;
		for (int i = 0; i < NUM_LINES; i++) begin
			mark[i] = (i >= int'(lo_line)) && (i <= int'(hi_line));
			if (lowest[i]) begin
				lowest_idx = lowest_idx | DIDX_W'(i);
			end
		end
	end

	assign lowest    = dirty_q & (~dirty_q + NUM_LINES'(1));
	assign fail_hit  = 32'(item_q.failed_line) < 32'(NUM_LINES);
	assign fail_mask = NUM_LINES'(1) << item_q.failed_line;

	always_comb begin
		dirty_d       = dirty_q;
		run_open_d    = run_open_q;
		run_changed_d = run_changed_q;
		run_start_d   = run_start_q;
		result_d      = '0;
		case (item_q.kind)
			dlwb_pkg::KIND_READ: begin
				result_d.read_data = in_store_q ? rdata_q : '0;
			end
			dlwb_pkg::KIND_WRITE: begin
				if (item_q.block_end) begin
					if (changed) begin
						dirty_d = dirty_q | mark;
					end
					run_open_d    = 1'b0;
					run_changed_d = 1'b0;
				end else begin
					run_open_d    = 1'b1;
					run_changed_d = changed;
					run_start_d   = first_line;
				end
			end
			dlwb_pkg::KIND_TICK: begin
				if (|dirty_q) begin
					dirty_d             = dirty_q & ~lowest;
					result_d.line_valid = 1'b1;
					result_d.line_index = OIW'(lowest_idx);
				end
			end
			dlwb_pkg::KIND_FAIL: begin
				if (fail_hit) begin
					dirty_d = dirty_q | fail_mask;
				end
			end
			default: begin
				result_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q       <= '0;
			run_open_q    <= 1'b0;
			run_changed_q <= 1'b0;
			run_start_q   <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish) begin
				dirty_q       <= dirty_d;
				run_open_q    <= run_open_d;
				run_changed_q <= run_changed_d;
				run_start_q   <= run_start_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: rtl/dirty_line_writeback_buffer_unit.sv
// ----------------------------------------------------------------------------
// Dirty-line write-back buffer
// Timing: the accepted item and the old store byte are registered, then in
// the busy state the result and done are registered; done marks the result.
// Flow: no item is taken while busy; busy is high for the one cycle in
// which the single-port byte store's read data is compared and used.
// Reset: arst_n clears the dirty lines, the open write run and the strobe.
// The byte store has no reset and holds nothing until loaded or written.
// Results cannot be stalled; each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module dirty_line_writeback_buffer_unit #(
	parameter int STORE_BYTES = dlwb_pkg::STORE_BYTES_DEF,
	parameter int LINE_SHIFT  = dlwb_pkg::LINE_SHIFT_DEF,
	parameter int NUM_LINES   = dlwb_pkg::NUM_LINES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dlwb_pkg::item_t   item,
	output logic              done,
	output dlwb_pkg::result_t result
);

	dlwb_pkg::cmd_t cmd;

	dlwb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	dlwb_datapath #(
		.STORE_BYTES (STORE_BYTES),
		.LINE_SHIFT  (LINE_SHIFT),
		.NUM_LINES   (NUM_LINES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.done   (done),
		.result (result)
	);

endmodule

// File: rtl/dlwb_checker.sv
// ----------------------------------------------------------------------------
// Dirty-line write-back buffer port checker
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module dlwb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input dlwb_pkg::result_t result
);

	logic accept;
	assign accept = start && !busy;

	assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy)
		else $error("busy did not follow an accepted item");

	assert property (@(posedge clk) disable iff (!arst_n) accept |=> ##1 done)
		else $error("no result two cycles after an accepted item");

	assert property (@(posedge clk) disable iff (!arst_n) busy |=> !busy)
		else $error("busy lasted longer than one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && !$past(accept))
		else $error("result strobe out of step with the item flow");

	assert property (@(posedge clk) disable iff (!arst_n)
		done && result.line_valid |-> result.read_data == '0)
		else $error("issued line came with read data");

endmodule

bind dirty_line_writeback_buffer_unit dlwb_checker u_dlwb_checker (.*);

// File: bench/tb_dirty_line_writeback_buffer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the dirty-line write-back buffer
// Drives read, write, load, tick and write-out failure items through the
// start/busy handshake. It keeps its own mirror of the byte store, the dirty
// lines and the open write run, and checks every strobed result in order.
// ----------------------------------------------------------------------------
module tb_dirty_line_writeback_buffer_unit;

	localparam int KIND_UNUSED_FIRST = 5;
	localparam int KIND_UNUSED_LAST  = 7;
	localparam int ADDR_MAX          = dlwb_pkg::STORE_BYTES_DEF - 1;
	localparam int STORE_N           = dlwb_pkg::STORE_BYTES_DEF;
	localparam int LINES_N           = dlwb_pkg::NUM_LINES_DEF;
	localparam int AW                = dlwb_pkg::ADDR_W;
	localparam int DW                = dlwb_pkg::DATA_W;
	localparam int KW                = dlwb_pkg::KIND_W;
	localparam int FW                = dlwb_pkg::FLINE_W;
	localparam int LW                = dlwb_pkg::LIDX_W;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	dlwb_pkg::item_t   item   = '0;
	logic              busy;
	logic              done;
	dlwb_pkg::result_t result;

	dlwb_pkg::item_t   pending_items[$];
	dlwb_pkg::result_t expected_results[$];

	// Generator view of the store: which bytes hold data, and what they hold.
	logic          gen_known [STORE_N];
	logic [DW-1:0] gen_bytes [STORE_N];
	logic [AW-1:0] known_addrs[$];

	// Mirror of the block's state.
	logic [DW-1:0]      mirror_bytes [STORE_N];
	logic [LINES_N-1:0] mirror_dirty = '0;
	logic               run_active   = 1'b0;
	logic               run_dirtied  = 1'b0;
	logic [LW-1:0]      run_first_line = '0;

	int sender_idle_pct = 0;
	int mismatch_count  = 0;
	int items_accepted  = 0;
	int results_checked = 0;
	int lines_issued    = 0;
	int runs_marked     = 0;

	dirty_line_writeback_buffer_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		mismatch_count++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	function automatic dlwb_pkg::result_t predict_buffer_result(dlwb_pkg::item_t it);
		dlwb_pkg::result_t r;
		logic [LW-1:0]     ln;
		logic [LW-1:0]     lo;
		logic [LW-1:0]     hi;
		r  = '0;
		ln = it.address[AW-1:dlwb_pkg::LINE_SHIFT_DEF];
		case (it.kind)
			dlwb_pkg::KIND_READ: begin
				r.read_data = mirror_bytes[it.address];
			end
			dlwb_pkg::KIND_WRITE: begin
				if (!run_active) begin
					run_active     = 1'b1;
					run_first_line = ln;
					run_dirtied    = 1'b0;
				end
				if (mirror_bytes[it.address] != it.data_byte) begin
					mirror_bytes[it.address] = it.data_byte;
					run_dirtied = 1'b1;
				end
				if (it.block_end) begin
					if (run_dirtied) begin
						lo = (run_first_line < ln) ? run_first_line : ln;
						hi = (run_first_line < ln) ? ln : run_first_line;
						for (int i = 0; i < LINES_N; i++) begin
							if (i >= lo && i <= hi) begin
								mirror_dirty[i] = 1'b1;
							end
						end
						runs_marked++;
					end
					run_active  = 1'b0;
					run_dirtied = 1'b0;
				end
			end
			dlwb_pkg::KIND_LOAD: begin
				mirror_bytes[it.address] = it.data_byte;
			end
			dlwb_pkg::KIND_TICK: begin
				for (int i = 0; i < LINES_N; i++) begin
					if (!r.line_valid && mirror_dirty[i]) begin
						mirror_dirty[i] = 1'b0;
						r.line_valid    = 1'b1;
						r.line_index    = LW'(i);
					end
				end
			end
			dlwb_pkg::KIND_FAIL: begin
				mirror_dirty[it.failed_line] = 1'b1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic void queue_item(logic [KW-1:0] k, logic [AW-1:0] a,
			logic [DW-1:0] d, logic last, logic [FW-1:0] fl);
		dlwb_pkg::item_t it;
		it.kind        = k;
		it.address     = a;
		it.data_byte   = d;
		it.block_end   = last;
		it.failed_line = fl;
		pending_items.push_back(it);
		if (k == dlwb_pkg::KIND_LOAD || k == dlwb_pkg::KIND_WRITE) begin
			if (!gen_known[a]) begin
				gen_known[a] = 1'b1;
				known_addrs.push_back(a);
			end
			gen_bytes[a] = d;
		end
	endfunction

	function automatic logic [AW-1:0] any_known_addr();
		return known_addrs[$urandom_range(known_addrs.size() - 1)];
	endfunction

	// Reads, loads, ticks, failures and unused kinds; all of these may also
	// fall inside an open write run.
	function automatic void queue_background_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35) begin
			queue_item(dlwb_pkg::KIND_READ, any_known_addr(), DW'($urandom),
				1'($urandom), FW'($urandom));
		end else if (pick < 48) begin
			queue_item(dlwb_pkg::KIND_LOAD, AW'($urandom_range(ADDR_MAX)), DW'($urandom),
				1'($urandom), FW'($urandom));
		end else if (pick < 78) begin
			queue_item(dlwb_pkg::KIND_TICK, AW'($urandom), DW'($urandom),
				1'($urandom), FW'($urandom));
		end else if (pick < 90) begin
			queue_item(dlwb_pkg::KIND_FAIL, AW'($urandom), DW'($urandom),
				1'($urandom), FW'($urandom));
		end else begin
			queue_item(KW'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST)),
				AW'($urandom), DW'($urandom), 1'($urandom), FW'($urandom));
		end
	endfunction

	function automatic void queue_random_traffic(int target);
		int            n;
		logic [AW-1:0] a;
		logic [DW-1:0] d;
		while (pending_items.size() < target) begin
			if ($urandom_range(99) < 45) begin
				n = $urandom_range(6, 1);
				for (int j = 0; j < n; j++) begin
					a = any_known_addr();
					d = ($urandom_range(99) < 30) ? gen_bytes[a] : DW'($urandom);
					// Now and then a run is left open and runs on into the next one.
					queue_item(dlwb_pkg::KIND_WRITE, a, d,
						(j == n - 1) && ($urandom_range(19) != 0), FW'($urandom));
					if (j < n - 1 && $urandom_range(4) == 0) begin
						queue_background_item();
					end
				end
			end else begin
				queue_background_item();
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item  <= '0;
		end else if (!start || !busy) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				start <= 1'b1;
				item  <= pending_items.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		dlwb_pkg::result_t want;
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(predict_buffer_result(item));
				items_accepted++;
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result with no item outstanding (%h)", result));
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (want.line_valid) begin
						lines_issued++;
					end
					if (result.read_data !== want.read_data) begin
						report_mismatch($sformatf("read_data %h, expected %h",
							result.read_data, want.read_data));
					end
					if (result.line_valid !== want.line_valid) begin
						report_mismatch($sformatf("line_valid %b, expected %b",
							result.line_valid, want.line_valid));
					end
					if (result.line_index !== want.line_index) begin
						report_mismatch($sformatf("line_index %0d, expected %0d",
							result.line_index, want.line_index));
					end
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < STORE_N; i++) begin
			gen_known[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: empty tick, extreme bytes, unchanged run, runs in
		// both directions with other items inside them, failures and unused kinds.
		queue_item(dlwb_pkg::KIND_TICK, '0, '0, 1'b0, '0);
		queue_item(dlwb_pkg::KIND_LOAD, 12'h000, 8'h00, 1'b0, '0);
		queue_item(dlwb_pkg::KIND_LOAD, 12'hFFF, 8'hFF, 1'b1, 3'd7);
		queue_item(dlwb_pkg::KIND_LOAD, 12'h5A5, 8'hA5, 1'b0, '0);
		queue_item(dlwb_pkg::KIND_LOAD, 12'h1FF, 8'h80, 1'b0, '0);
		queue_item(dlwb_pkg::KIND_READ, 12'h000, '0, 1'b0, '0);
		queue_item(dlwb_pkg::KIND_READ, 12'hFFF, 8'hFF, 1'b1, 3'd7);
		queue_item(dlwb_pkg::KIND_WRITE, 12'h000, 8'h00, 1'b1, '0);
		queue_item(dlwb_pkg::KIND_TICK, '0, '0, 1'b0, '0);
		queue_item(dlwb_pkg::KIND_WRITE, 12'h1FF, 8'h11, 1'b0, '0);
		queue_item(dlwb_pkg::KIND_READ, 12'h1FF, '0, 1'b0, '0);
		queue_item(dlwb_pkg::KIND_WRITE, 12'h5A5, 8'h5A, 1'b1, '0);
		queue_item(dlwb_pkg::KIND_WRITE, 12'hFFF, 8'h00, 1'b0, '0);
		queue_item(dlwb_pkg::KIND_FAIL, '0, '0, 1'b0, 3'd7);
		queue_item(dlwb_pkg::KIND_WRITE, 12'h5A5, 8'h5A, 1'b1, '0);
		queue_item(dlwb_pkg::KIND_TICK, '0, '0, 1'b0, '0);
		queue_item(dlwb_pkg::KIND_TICK, '0, '0, 1'b0, '0);
		queue_item(dlwb_pkg::KIND_TICK, '0, '0, 1'b0, '0);
		queue_item(dlwb_pkg::KIND_FAIL, '0, '0, 1'b0, 3'd0);
		queue_item(dlwb_pkg::KIND_TICK, '0, '0, 1'b0, '0);
		for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++) begin
			queue_item(KW'(k), 12'hFFF, 8'hFF, 1'b1, 3'd7);
		end
		queue_item(dlwb_pkg::KIND_READ, 12'h5A5, '0, 1'b0, '0);

		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 87 : 0;
			queue_random_traffic((phase == 0) ? 620 : 615);
			while (pending_items.size() != 0) begin
				@(posedge clk);
			end
		end

		while (pending_items.size() != 0 || start || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		end

		$display("Ran %0d items: %0d write runs marked lines dirty, %0d lines issued.",
			items_accepted, runs_marked, lines_issued);
		$display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d items queued and %0d results outstanding.",
			pending_items.size(), expected_results.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
